// File: sv/djs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_pkg
// types and constants shared by the deadline job selector modules
// ----------------------------------------------------------------------------
package djs_pkg;

  localparam int IdWidth     = 16;
  localparam int DlWidth     = 16;
  localparam int ProfitWidth = 24;

  typedef struct packed {
    logic [IdWidth-1:0]     id;
    logic [DlWidth-1:0]     deadline;
    logic [ProfitWidth-1:0] profit;
  } entry_t;

  typedef enum logic [1:0] {
    Q_HOLD,
    Q_POP,
    Q_PUSH,
    Q_CLEAR
  } q_op_t;

  typedef struct packed {
    q_op_t  op;
    entry_t entry;
  } q_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_POP1,
    S_PUSH,
    S_POP2,
    S_STATUS,
    S_FIN
  } state_t;

endpackage

// File: sv/djs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_cell
// one slot of the profit-ordered shift queue, talks to its two neighbours
// ----------------------------------------------------------------------------
module djs_cell (
  input  logic            clk,
  input  logic            rst,
  input  djs_pkg::q_cmd_t cmd,
  input  logic            left_ge,
  input  logic            left_valid,
  input  djs_pkg::entry_t left_entry,
  input  logic            right_valid,
  input  djs_pkg::entry_t right_entry,
  output logic            valid,
  output djs_pkg::entry_t entry,
  output logic            ge
);

  // own entry stays ahead of the incoming one (ties keep load order)
  assign ge = valid && (entry.profit >= cmd.entry.profit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        djs_pkg::Q_POP: begin
          valid <= right_valid;
        end
        djs_pkg::Q_PUSH: begin
          if (!ge) begin
            valid <= left_ge ? 1'b1 : left_valid;
          end
        end
        djs_pkg::Q_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      djs_pkg::Q_POP: begin
        entry <= right_entry;
      end
      djs_pkg::Q_PUSH: begin
        if (!ge) begin
          entry <= left_ge ? cmd.entry : left_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// File: sv/djs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_queue
// chain of cells forming a sorted queue, highest profit at the head
// ----------------------------------------------------------------------------
module djs_queue #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  djs_pkg::q_cmd_t cmd,
  output djs_pkg::entry_t head
);

  logic            valid_w [DEPTH];
  djs_pkg::entry_t entry_w [DEPTH];
  logic            ge_w    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            l_ge;
    logic            l_valid;
    djs_pkg::entry_t l_entry;
    logic            r_valid;
    djs_pkg::entry_t r_entry;

    if (i == 0) begin : g_head
      assign l_ge    = 1'b1;
      assign l_valid = 1'b0;
      assign l_entry = '0;
    end else begin : g_mid
      assign l_ge    = ge_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = '0;
    end else begin : g_body
      assign r_valid = valid_w[i+1];
      assign r_entry = entry_w[i+1];
    end

    djs_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_ge     (l_ge),
      .left_valid  (l_valid),
      .left_entry  (l_entry),
      .right_valid (r_valid),
      .right_entry (r_entry),
      .valid       (valid_w[i]),
      .entry       (entry_w[i]),
      .ge          (ge_w[i])
    );
  end

  assign head = entry_w[0];

endmodule

// File: sv/deadline_job_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_job_selector_core
// greedy job sequencing with deadlines over a systolic priority queue
// ----------------------------------------------------------------------------
// Jobs arrive one per input transaction in non-increasing deadline order and
// are held in a chain of QUEUE_DEPTH cells kept sorted by profit. Each input
// produces one output transaction per selected job (tuser[0] high), or one
// status-only transaction when nothing is selected; tlast marks the final one.
// The cell chain shifts out one job per cycle while the output register is free;
// output back-pressure holds the shifting until the register frees.
// A new job is accepted only once every result of the previous one has been
// handed to the output register.
module deadline_job_selector_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // job_id, job_deadline, job_profit
  input  logic        s_tlast,  // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // sel_id, sel_deadline, sel_profit
  output logic [2:0]  m_tuser,  // selected, order_error, overflow
  output logic        m_tlast   // run_end
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  djs_pkg::state_t state, state_next;
  djs_pkg::q_cmd_t q_cmd;
  djs_pkg::entry_t head;

  djs_pkg::entry_t in_entry;
  logic            in_last;
  logic [15:0]     prev_dl;
  logic            have_prev;
  logic [CW-1:0]   count;
  logic [CW-1:0]   rem1;
  logic [CW-1:0]   rem2;
  logic            push_ok;
  logic            oerr;
  logic            nores;

  logic [15:0]     slots1;
  logic [CW-1:0]   p1;
  logic [CW-1:0]   cnt1;
  logic            push_ok_next;
  logic [CW-1:0]   cnt2;
  logic [CW-1:0]   p2;
  logic            oerr_next;

  logic            out_free;
  logic            emit;
  logic            emit_job;
  logic            emit_end;

  logic            o_valid;
  djs_pkg::entry_t o_entry;
  logic            o_sel;
  logic            o_end;
  logic            o_oerr;
  logic            o_ovf;

  djs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (q_cmd),
    .head (head)
  );

  // pop planning
  always_comb begin
    oerr_next = have_prev && (in_entry.deadline > prev_dl);
    slots1    = (have_prev && !oerr_next) ? (prev_dl - in_entry.deadline) : 16'd0;
    p1        = (slots1 >= 16'(count)) ? count : slots1[CW-1:0];
    cnt1      = count - p1;
    push_ok_next = cnt1 < DepthC;
    cnt2      = cnt1 + CW'(push_ok_next);
    if (in_last) begin
      p2 = (in_entry.deadline >= 16'(cnt2)) ? cnt2 : in_entry.deadline[CW-1:0];
    end else begin
      p2 = '0;
    end
  end

  assign out_free = !o_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      djs_pkg::S_IDLE: begin
        if (s_tvalid) state_next = djs_pkg::S_PLAN;
      end
      djs_pkg::S_PLAN: begin
        state_next = (p1 != '0) ? djs_pkg::S_POP1 : djs_pkg::S_PUSH;
      end
      djs_pkg::S_POP1: begin
        if (out_free && rem1 == CW'(1)) state_next = djs_pkg::S_PUSH;
      end
      djs_pkg::S_PUSH: begin
        if (rem2 != '0) state_next = djs_pkg::S_POP2;
        else if (nores) state_next = djs_pkg::S_STATUS;
        else state_next = djs_pkg::S_FIN;
      end
      djs_pkg::S_POP2: begin
        if (out_free && rem2 == CW'(1)) state_next = djs_pkg::S_FIN;
      end
      djs_pkg::S_STATUS: begin
        if (out_free) state_next = djs_pkg::S_FIN;
      end
      djs_pkg::S_FIN: begin
        state_next = djs_pkg::S_IDLE;
      end
      default: begin
        state_next = djs_pkg::S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_tready     = 1'b0;
    q_cmd.op     = djs_pkg::Q_HOLD;
    q_cmd.entry  = in_entry;
    emit         = 1'b0;
    emit_job     = 1'b0;
    emit_end     = 1'b0;
    unique case (state)
      djs_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      djs_pkg::S_POP1: begin
        if (out_free) begin
          q_cmd.op = djs_pkg::Q_POP;
          emit     = 1'b1;
          emit_job = 1'b1;
          emit_end = (rem1 == CW'(1)) && (rem2 == '0);
        end
      end
      djs_pkg::S_PUSH: begin
        if (push_ok) q_cmd.op = djs_pkg::Q_PUSH;
      end
      djs_pkg::S_POP2: begin
        if (out_free) begin
          q_cmd.op = djs_pkg::Q_POP;
          emit     = 1'b1;
          emit_job = 1'b1;
          emit_end = rem2 == CW'(1);
        end
      end
      djs_pkg::S_STATUS: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_end = 1'b1;
        end
      end
      djs_pkg::S_FIN: begin
        if (in_last) q_cmd.op = djs_pkg::Q_CLEAR;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= djs_pkg::S_IDLE;
      count     <= '0;
      prev_dl   <= '0;
      have_prev <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      if (q_cmd.op == djs_pkg::Q_POP) begin
        count <= count - CW'(1);
      end else if (q_cmd.op == djs_pkg::Q_PUSH) begin
        count <= count + CW'(1);
      end else if (q_cmd.op == djs_pkg::Q_CLEAR) begin
        count <= '0;
      end
      if (state == djs_pkg::S_FIN) begin
        prev_dl   <= in_last ? 16'd0 : in_entry.deadline;
        have_prev <= !in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_entry.id       <= s_tdata[15:0];
      in_entry.deadline <= s_tdata[31:16];
      in_entry.profit   <= s_tdata[55:32];
      in_last           <= s_tlast;
    end
    if (state == djs_pkg::S_PLAN) begin
      rem1    <= p1;
      rem2    <= p2;
      push_ok <= push_ok_next;
      oerr    <= oerr_next;
      nores   <= (p1 == '0) && (p2 == '0);
    end else if (state == djs_pkg::S_POP1 && emit) begin
      rem1 <= rem1 - CW'(1);
    end else if (state == djs_pkg::S_POP2 && emit) begin
      rem2 <= rem2 - CW'(1);
    end
    if (emit) begin
      o_entry <= emit_job ? head : '0;
      o_sel   <= emit_job;
      o_end   <= emit_end;
      o_oerr  <= oerr;
      o_ovf   <= !push_ok;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_entry.profit, o_entry.deadline, o_entry.id};
  assign m_tuser  = {o_ovf, o_oerr, o_sel};
  assign m_tlast  = o_end;

endmodule

// File: sv/djs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djs_checker
// port-level checks on the deadline job selector
// ----------------------------------------------------------------------------
module djs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // one job in flight at a time
  a_one_job: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a job was in flight");

  // a status-only transaction carries no job and closes the run
  a_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 56'd0))
    else $error("bad status-only transaction");

  // when idle, any pending result is the last of its run
  a_idle_end: assert property (@(posedge clk) disable iff (rst)
    (s_tready && m_tvalid) |-> m_tlast)
    else $error("idle with unfinished run");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("output changed while stalled");

endmodule

bind deadline_job_selector_core djs_checker u_djs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
